>>> rtl/nwc_pkg.sv
package nwc_pkg;

    // Default sizes
    localparam int TUPLE_BITS_DEF   = 8;
    localparam int NUM_TUPLES_DEF   = 128;
    localparam int IMAGE_PIXELS_DEF = 1024;
    localparam int NUM_CLASSES_DEF  = 4;

    // Register reset values
    localparam logic [7:0] THRESHOLD_RST   = 8'd127;
    localparam logic [2:0] CLASS_COUNT_RST = 3'd2;

    // Configuration register indexes
    localparam logic CFG_THRESHOLD   = 1'b0;
    localparam logic CFG_CLASS_COUNT = 1'b1;

    // Request codes
    typedef enum logic [2:0] {
        REQ_PIXEL = 3'd0,
        REQ_CONN  = 3'd1,
        REQ_TRAIN = 3'd2,
        REQ_RECOG = 3'd3,
        REQ_CLEAR = 3'd4
    } req_code_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [9:0] index;
        logic [9:0] value;
        logic [1:0] class_id;
    } req_beat_t;

    typedef struct packed {
        logic       status;
        logic [1:0] result_class;
        logic [7:0] hit_count;
        logic [1:0] winner;
        logic       last;
    } rsp_beat_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_SCAN,
        ST_WIN,
        ST_EMIT,
        ST_ACK
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic sweep_run;
        logic sweep_all;
        logic capture;
        logic pix_wr;
        logic map_wr;
        logic scan_start;
        logic win_step;
        logic cp_clear;
        logic emit;
        logic ack;
        logic ack_bad;
    } nwc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       sweep_done;
        logic [2:0] req;
        logic       bad_class;
        logic       no_class;
        logic       scan_done;
        logic       cp_last;
        logic       out_free;
    } nwc_sts_t;

endpackage

>>> rtl/nwc_ctrl.sv
module nwc_ctrl
    import nwc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  nwc_sts_t sts,
    output nwc_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (sts.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (sts.req)
                    REQ_TRAIN:
                    begin
                        state_next = sts.bad_class ? ST_ACK : ST_SCAN;
                    end
                    REQ_RECOG:
                    begin
                        state_next = sts.no_class ? ST_IDLE : ST_SCAN;
                    end
                    REQ_CLEAR:
                    begin
                        state_next = ST_CLEAR;
                    end
                    default:
                    begin
                        state_next = ST_ACK;
                    end
                endcase
            end
            ST_CLEAR:
            begin
                if (sts.sweep_done)
                begin
                    state_next = ST_ACK;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = (sts.req == REQ_RECOG) ? ST_WIN : ST_ACK;
                end
            end
            ST_WIN:
            begin
                if (sts.cp_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.cp_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACK:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_run = 1'b1;
                cmd.sweep_all = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DECODE:
            begin
                cmd.pix_wr     = (sts.req == REQ_PIXEL);
                cmd.map_wr     = (sts.req == REQ_CONN);
                cmd.scan_start = ((sts.req == REQ_TRAIN) && !sts.bad_class)
                              || ((sts.req == REQ_RECOG) && !sts.no_class);
            end
            ST_CLEAR:
            begin
                cmd.sweep_run = 1'b1;
            end
            ST_WIN:
            begin
                cmd.win_step = 1'b1;
                cmd.cp_clear = sts.cp_last;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            ST_ACK:
            begin
                cmd.ack     = sts.out_free;
                cmd.ack_bad = (sts.req == REQ_TRAIN) && sts.bad_class;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/nwc_dp.sv
module nwc_dp
    import nwc_pkg::*;
#(
    parameter int TUPLE_BITS   = TUPLE_BITS_DEF,
    parameter int NUM_TUPLES   = NUM_TUPLES_DEF,
    parameter int IMAGE_PIXELS = IMAGE_PIXELS_DEF,
    parameter int NUM_CLASSES  = NUM_CLASSES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_beat_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output rsp_beat_t  out_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  nwc_cmd_t   cmd,
    output nwc_sts_t   sts
);

    localparam int MAP_SLOTS = NUM_TUPLES * TUPLE_BITS;
    localparam int TA        = 1 << TUPLE_BITS;
    localparam int MSW       = $clog2(MAP_SLOTS);
    localparam int PIX_W     = (MSW > 10) ? MSW : 10;
    localparam int PXA_W     = $clog2(IMAGE_PIXELS);
    localparam int TW        = (NUM_TUPLES > 1) ? $clog2(NUM_TUPLES) : 1;
    localparam int JW        = $clog2(TUPLE_BITS);
    localparam int CPW       = $clog2(NUM_CLASSES);
    localparam int CW        = $clog2(NUM_TUPLES + 1);
    localparam int SWEEP_A   = (IMAGE_PIXELS > MAP_SLOTS) ? IMAGE_PIXELS : MAP_SLOTS;
    localparam int SWEEP_N   = (SWEEP_A > NUM_TUPLES) ? SWEEP_A : NUM_TUPLES;
    localparam int SW        = $clog2(SWEEP_N);

    // Memories
    logic                            pix_mem   [IMAGE_PIXELS];
    logic [PIX_W-1:0]                map_mem   [MAP_SLOTS];
    logic [NUM_CLASSES-1:0][TA-1:0]  store_mem [NUM_TUPLES];

    // Configuration
    logic [7:0] thr_reg;
    logic [2:0] ccount_reg;
    logic [2:0] ncls;

    // Captured request
    req_beat_t req_reg;

    // Sweep
    logic [SW-1:0] sw_reg;
    logic          sw_end;

    // Scan pipeline
    logic                           s_run_reg;
    logic [MSW-1:0]                 s_reg;
    logic [JW-1:0]                  j0_reg;
    logic [TW-1:0]                  t0_reg;
    logic                           v1_reg;
    logic [JW-1:0]                  j1_reg;
    logic [TW-1:0]                  t1_reg;
    logic [PIX_W-1:0]               map_q_reg;
    logic                           v2_reg;
    logic [JW-1:0]                  j2_reg;
    logic [TW-1:0]                  t2_reg;
    logic                           rng2_reg;
    logic                           pix_q_reg;
    logic [TUPLE_BITS-1:0]          addr_sh_reg;
    logic [TUPLE_BITS-1:0]          full_addr;
    logic                           v3_reg;
    logic [TUPLE_BITS-1:0]          a3_reg;
    logic [TW-1:0]                  t3_reg;
    logic [NUM_CLASSES-1:0][TA-1:0] store_q_reg;
    logic [NUM_CLASSES-1:0][TA-1:0] row_next;
    logic                           s_last;
    logic [CPW-1:0]                 cls_c;
    logic                           is_train;

    // Counts and winner
    logic [CW-1:0]  cnt_reg [NUM_CLASSES];
    logic [CW-1:0]  best_reg;
    logic [CPW-1:0] win_reg;
    logic [CPW-1:0] cp_reg;

    // Output register
    logic      out_valid_reg;
    rsp_beat_t out_reg;
    logic      out_free;

    assign ncls     = (32'(ccount_reg) < NUM_CLASSES) ? ccount_reg : 3'(NUM_CLASSES);
    assign sw_end   = cmd.sweep_all ? (sw_reg == SW'(SWEEP_N - 1))
                                    : (sw_reg == SW'(NUM_TUPLES - 1));
    assign s_last   = (s_reg == MSW'(MAP_SLOTS - 1));
    assign full_addr = {addr_sh_reg[TUPLE_BITS-2:0], pix_q_reg & rng2_reg};
    assign cls_c    = CPW'(req_reg.class_id);
    assign is_train = (req_reg.req_type == REQ_TRAIN);
    assign out_free = !out_valid_reg || out_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THRESHOLD_RST;
            ccount_reg <= CLASS_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:   thr_reg    <= cfg_data;
                CFG_CLASS_COUNT: ccount_reg <= cfg_data[2:0];
                default:         thr_reg    <= thr_reg;
            endcase
        end
    end

    // Capture request beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= in_data;
        end
    end

    // Sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= '0;
        end
        else if (cmd.sweep_run)
        begin
            sw_reg <= sw_end ? '0 : sw_reg + 1'b1;
        end
    end

    // Pixel memory: sweep clear or thresholded write; read at mapped pixel
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_run && cmd.sweep_all && (32'(sw_reg) < IMAGE_PIXELS))
        begin
            pix_mem[PXA_W'(sw_reg)] <= 1'b0;
        end
        else if (cmd.pix_wr && (32'(req_reg.index) < IMAGE_PIXELS))
        begin
            pix_mem[PXA_W'(req_reg.index)] <= (req_reg.value > {2'b00, thr_reg});
        end
        pix_q_reg <= pix_mem[PXA_W'(map_q_reg)];
    end

    // Connection map: identity fill or slot write; read at scan slot
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_run && cmd.sweep_all && (32'(sw_reg) < MAP_SLOTS))
        begin
            map_mem[MSW'(sw_reg)] <= PIX_W'(sw_reg);
        end
        else if (cmd.map_wr && (32'(req_reg.index) < MAP_SLOTS))
        begin
            map_mem[MSW'(req_reg.index)] <= PIX_W'(req_reg.value);
        end
        map_q_reg <= map_mem[s_reg];
    end

    // Train row update: set the addressed bit of the class
    always_comb
    begin
        row_next = store_q_reg;
        row_next[cls_c][a3_reg] = 1'b1;
    end

    // Tuple store: clear or train write; read at tuple of stage two
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_run && (32'(sw_reg) < NUM_TUPLES))
        begin
            store_mem[TW'(sw_reg)] <= '0;
        end
        else if (v3_reg && is_train && (a3_reg != '0))
        begin
            store_mem[t3_reg] <= row_next;
        end
        store_q_reg <= store_mem[t2_reg];
    end

    // Scan control: walk map slots, advance the pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_run_reg <= 1'b0;
            s_reg     <= '0;
            j0_reg    <= '0;
            t0_reg    <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                s_run_reg <= 1'b1;
                s_reg     <= '0;
                j0_reg    <= '0;
                t0_reg    <= '0;
            end
            else if (s_run_reg)
            begin
                s_run_reg <= !s_last;
                s_reg     <= s_reg + 1'b1;
                if (j0_reg == JW'(TUPLE_BITS - 1))
                begin
                    j0_reg <= '0;
                    t0_reg <= t0_reg + 1'b1;
                end
                else
                begin
                    j0_reg <= j0_reg + 1'b1;
                end
            end
            v1_reg <= s_run_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && (j2_reg == JW'(TUPLE_BITS - 1));
        end
    end

    // Scan payload stages
    always_ff @(posedge clk)
    begin
        j1_reg   <= j0_reg;
        t1_reg   <= t0_reg;
        j2_reg   <= j1_reg;
        t2_reg   <= t1_reg;
        rng2_reg <= (32'(map_q_reg) < IMAGE_PIXELS);
        t3_reg   <= t2_reg;
        a3_reg   <= full_addr;
        if (v2_reg)
        begin
            addr_sh_reg <= full_addr;
        end
    end

    // Hit counters
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (cmd.scan_start)
            begin
                cnt_reg[c] <= '0;
            end
            else if (v3_reg && !is_train && store_q_reg[c][a3_reg])
            begin
                cnt_reg[c] <= cnt_reg[c] + 1'b1;
            end
        end
    end

    // Winner search and class pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg <= '0;
        end
        else if (cmd.scan_start || cmd.cp_clear)
        begin
            cp_reg <= '0;
        end
        else if (cmd.win_step || cmd.emit)
        begin
            cp_reg <= cp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            best_reg <= '0;
            win_reg  <= '0;
        end
        else if (cmd.win_step && (cnt_reg[cp_reg] > best_reg))
        begin
            best_reg <= cnt_reg[cp_reg];
            win_reg  <= cp_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.ack)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.status       <= 1'b0;
            out_reg.result_class <= 2'(cp_reg);
            out_reg.hit_count    <= (32'(cnt_reg[cp_reg]) > 255) ? 8'hFF
                                                                : 8'(cnt_reg[cp_reg]);
            out_reg.winner       <= 2'(win_reg);
            out_reg.last         <= sts.cp_last;
        end
        else if (cmd.ack)
        begin
            out_reg <= '{status: cmd.ack_bad, result_class: 2'd0, hit_count: 8'd0,
                         winner: 2'd0, last: 1'b1};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Status to controller
    assign sts.sweep_done = cmd.sweep_run && sw_end;
    assign sts.req        = req_reg.req_type;
    assign sts.bad_class  = ({1'b0, req_reg.class_id} >= ncls);
    assign sts.no_class   = (ncls == 3'd0);
    assign sts.scan_done  = v3_reg && (t3_reg == TW'(NUM_TUPLES - 1));
    assign sts.cp_last    = ((32'(cp_reg) + 1) == 32'(ncls));
    assign sts.out_free   = out_free;

endmodule

>>> rtl/ntuple_weightless_classifier_core.sv
// N-tuple (WiSARD style) classifier. Each request beat with a defined code takes one of
// five actions: a pixel write thresholds the value against pixel_threshold into a 1-bit
// image, a connection write reloads one slot of the pixel map, train sets one address bit
// per tuple for a class unless that address is zero, recognize reports a hit count per
// active class with the winning class, and clear zeroes the tuple store. Every request
// but recognize returns one ack beat; recognize returns one beat per active class, last
// set on the final one. After reset the block sweeps its memories, clearing the image and
// the tuple store and loading an identity connection map, before taking a request;
// configuration writes are taken any time. Train walks the connection map one slot a
// cycle through a single map read port; recognize walks the same map, then searches the
// active classes for the winner and returns one result beat per class.
module ntuple_weightless_classifier_core
    import nwc_pkg::*;
#(
    parameter int TUPLE_BITS   = TUPLE_BITS_DEF,
    parameter int NUM_TUPLES   = NUM_TUPLES_DEF,
    parameter int IMAGE_PIXELS = IMAGE_PIXELS_DEF,
    parameter int NUM_CLASSES  = NUM_CLASSES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  req_beat_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output rsp_beat_t  out_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    nwc_cmd_t cmd;
    nwc_sts_t sts;

    // Sequencer
    nwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Memories, scan pipeline and result register
    nwc_dp #(
        .TUPLE_BITS   (TUPLE_BITS),
        .NUM_TUPLES   (NUM_TUPLES),
        .IMAGE_PIXELS (IMAGE_PIXELS),
        .NUM_CLASSES  (NUM_CLASSES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> sim/tb_top.sv
module tb_top;
    import nwc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TUPLE_BITS   = TUPLE_BITS_DEF;
    localparam int NUM_TUPLES   = NUM_TUPLES_DEF;
    localparam int IMAGE_PIXELS = IMAGE_PIXELS_DEF;
    localparam int NUM_CLASSES  = NUM_CLASSES_DEF;
    localparam int MAP_SLOTS    = NUM_TUPLES * TUPLE_BITS;
    localparam int TUPLE_ADDRS  = 1 << TUPLE_BITS;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    req_beat_t  in_data;
    logic       out_valid;
    logic       out_ready;
    rsp_beat_t  out_data;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    ntuple_weightless_classifier_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state
    logic [7:0] thresh_q;
    logic [2:0] class_cnt_q;
    logic       img_bits [IMAGE_PIXELS];
    logic [9:0] conn_map [MAP_SLOTS];
    logic       store [NUM_CLASSES][NUM_TUPLES][TUPLE_ADDRS];

    req_beat_t req_queue [$];
    rsp_beat_t rsp_queue [$];
    int        fail_count;
    bit        in_taken;
    bit        out_taken;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic mapped_bit(int slot);
        logic [9:0] p;
        p = conn_map[slot];
        if (p >= IMAGE_PIXELS)
            return 1'b0;
        return img_bits[p];
    endfunction

    function automatic int tuple_addr(int t);
        int a;
        a = 0;
        for (int j = 0; j < TUPLE_BITS; j++)
            a = ((a << 1) | mapped_bit(t * TUPLE_BITS + j)) & (TUPLE_ADDRS - 1);
        return a;
    endfunction

    // Work out the response beats of one accepted request
    task automatic predict_beat(req_beat_t r);
        rsp_beat_t  rsp;
        int         ncls;
        int         counts [NUM_CLASSES];
        int         best;
        int         win;
        int         a;
        ncls = (class_cnt_q < NUM_CLASSES) ? class_cnt_q : NUM_CLASSES;
        rsp = '0;
        rsp.last = 1'b1;
        case (r.req_type)
            REQ_PIXEL:
            begin
                if (r.index < IMAGE_PIXELS)
                    img_bits[r.index] = (r.value > thresh_q);
            end
            REQ_CONN:
            begin
                if (r.index < MAP_SLOTS)
                    conn_map[r.index] = r.value;
            end
            REQ_TRAIN:
            begin
                if (r.class_id >= ncls)
                    rsp.status = 1'b1;
                else
                    for (int t = 0; t < NUM_TUPLES; t++)
                    begin
                        a = tuple_addr(t);
                        if (a != 0)
                            store[r.class_id][t][a] = 1'b1;
                    end
            end
            REQ_RECOG:
            begin
                best = 0;
                win = 0;
                for (int c = 0; c < ncls; c++)
                begin
                    counts[c] = 0;
                    for (int t = 0; t < NUM_TUPLES; t++)
                        if (store[c][t][tuple_addr(t)])
                            counts[c]++;
                    if (counts[c] > best)
                    begin
                        best = counts[c];
                        win = c;
                    end
                end
                for (int c = 0; c < ncls; c++)
                begin
                    rsp = '0;
                    rsp.result_class = 2'(c);
                    rsp.hit_count = (counts[c] > 255) ? 8'd255 : 8'(counts[c]);
                    rsp.winner = 2'(win);
                    rsp.last = (c + 1 == ncls);
                    rsp_queue.push_back(rsp);
                end
                return;
            end
            REQ_CLEAR:
            begin
                for (int c = 0; c < NUM_CLASSES; c++)
                    for (int t = 0; t < NUM_TUPLES; t++)
                        for (int k = 0; k < TUPLE_ADDRS; k++)
                            store[c][t][k] = 1'b0;
            end
            default:
            begin
            end
        endcase
        rsp_queue.push_back(rsp);
    endtask

    // Mark the beats accepted at each rising edge
    always @(posedge clk)
    begin
        in_taken  <= rst_n && in_valid && in_ready;
        out_taken <= rst_n && out_valid && out_ready;
    end

    // Driver: present one beat after a random gap, hold until accepted
    int in_gap;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                // accepted at the last rising edge
                predict_beat(in_data);
                in_valid <= 1'b0;
                in_gap = $urandom_range(0, 19);
            end
            else if (!in_valid)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (req_queue.size() > 0)
                begin
                    in_data <= req_queue.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: compare each response beat with the oldest expectation
    int out_gap;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (rsp_queue.size() == 0)
            begin
                $error("unexpected response beat %p", out_data);
                fail_count++;
            end
            else
            begin
                rsp_beat_t e;
                e = rsp_queue.pop_front();
                if (out_data.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, out_data.status);
                    fail_count++;
                end
                if (out_data.result_class !== e.result_class)
                begin
                    $error("result_class exp %0d got %0d", e.result_class,
                           out_data.result_class);
                    fail_count++;
                end
                if (out_data.hit_count !== e.hit_count)
                begin
                    $error("hit_count exp %0d got %0d", e.hit_count, out_data.hit_count);
                    fail_count++;
                end
                if (out_data.winner !== e.winner)
                begin
                    $error("winner exp %0d got %0d", e.winner, out_data.winner);
                    fail_count++;
                end
                if (out_data.last !== e.last)
                begin
                    $error("last exp %0d got %0d", e.last, out_data.last);
                    fail_count++;
                end
            end
        end
    end

    // Stall the response side for a random count after each beat
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_gap = $urandom_range(0, 19);
                if (out_gap > 0)
                    out_ready <= 1'b0;
            end
            else if (!out_ready)
            begin
                if (out_gap > 0)
                    out_gap--;
                if (out_gap == 0)
                    out_ready <= 1'b1;
            end
        end
    end

    function automatic req_beat_t make_req(int rt, int idx, int val, int cls);
        req_beat_t r;
        r.req_type = 3'(rt);
        r.index = 10'(idx);
        r.value = 10'(val);
        r.class_id = 2'(cls);
        return r;
    endfunction

    // Wait until every queued beat is sent and answered, then settle
    task automatic drain();
        while (req_queue.size() > 0 || in_valid || rsp_queue.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, int data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 8'(data);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD)
            thresh_q = 8'(data);
        else
            class_cnt_q = 3'(data);
    endtask

    // Queue a random image, optionally a train for it, then a recognize
    task automatic queue_pattern(int npix, bit do_train);
        for (int i = 0; i < npix; i++)
            req_queue.push_back(make_req(REQ_PIXEL, $urandom_range(0, 1023),
                                         $urandom_range(0, 1023), $urandom()));
        if (do_train)
            req_queue.push_back(make_req(REQ_TRAIN, $urandom(), $urandom(), $urandom()));
        req_queue.push_back(make_req(REQ_RECOG, $urandom(), $urandom(), $urandom()));
    endtask

    initial
    begin
        int ph;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b1;
        cfg_we = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_data = '0;
        fail_count = 0;
        in_gap = 0;
        out_gap = 0;
        thresh_q = THRESHOLD_RST;
        class_cnt_q = CLASS_COUNT_RST;
        for (int i = 0; i < IMAGE_PIXELS; i++)
            img_bits[i] = 1'b0;
        for (int i = 0; i < MAP_SLOTS; i++)
            conn_map[i] = 10'(i);
        for (int c = 0; c < NUM_CLASSES; c++)
            for (int t = 0; t < NUM_TUPLES; t++)
                for (int a = 0; a < TUPLE_ADDRS; a++)
                    store[c][t][a] = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset defaults, extremes and the special cases
        req_queue.push_back(make_req(REQ_RECOG, 0, 0, 0));
        req_queue.push_back(make_req(REQ_TRAIN, 0, 0, 0));
        req_queue.push_back(make_req(REQ_PIXEL, 0, 128, 0));
        req_queue.push_back(make_req(REQ_PIXEL, 9, 127, 3));
        req_queue.push_back(make_req(REQ_PIXEL, 1023, 1023, 0));
        req_queue.push_back(make_req(REQ_PIXEL, 13, 300, 0));
        req_queue.push_back(make_req(REQ_TRAIN, 0, 0, 1));
        req_queue.push_back(make_req(REQ_TRAIN, 0, 0, 2));
        req_queue.push_back(make_req(REQ_TRAIN, 1023, 1023, 3));
        req_queue.push_back(make_req(REQ_RECOG, 1023, 1023, 3));
        req_queue.push_back(make_req(REQ_CONN, 1, 1023, 0));
        req_queue.push_back(make_req(REQ_CONN, 0, 1023, 0));
        req_queue.push_back(make_req(REQ_CONN, 1023, 0, 0));
        req_queue.push_back(make_req(REQ_CONN, 7, 0, 0));
        req_queue.push_back(make_req(REQ_RECOG, 0, 0, 0));
        req_queue.push_back(make_req(3'd5, 1023, 1023, 3));
        req_queue.push_back(make_req(3'd6, 0, 0, 0));
        req_queue.push_back(make_req(3'd7, 0, 512, 1));
        req_queue.push_back(make_req(REQ_CLEAR, 0, 0, 0));
        req_queue.push_back(make_req(REQ_RECOG, 0, 0, 0));
        drain();

        // Threshold and class count at zero, their lowest settings
        write_cfg(CFG_THRESHOLD, 8'd0);
        write_cfg(CFG_CLASS_COUNT, 3'd0);
        req_queue.push_back(make_req(REQ_PIXEL, 5, 1, 0));
        req_queue.push_back(make_req(REQ_TRAIN, 0, 0, 0));
        req_queue.push_back(make_req(REQ_RECOG, 0, 0, 0));
        req_queue.push_back(make_req(REQ_PIXEL, 6, 0, 0));
        drain();

        // Random phases: mostly images with train and recognize
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_cfg(CFG_THRESHOLD, 8'd255); write_cfg(CFG_CLASS_COUNT, 3'd4); end
                1: begin write_cfg(CFG_THRESHOLD, 8'd127); write_cfg(CFG_CLASS_COUNT, 3'd7); end
                2: begin write_cfg(CFG_THRESHOLD, 8'd0);   write_cfg(CFG_CLASS_COUNT, 3'd1); end
                3: write_cfg(CFG_CLASS_COUNT, 3'd3);
                default:
                begin
                    write_cfg(CFG_THRESHOLD, $urandom());
                    write_cfg(CFG_CLASS_COUNT, $urandom_range(1, 7));
                end
            endcase
            repeat (9)
            begin
                if ($urandom_range(0, 3) == 0)
                    req_queue.push_back(make_req(REQ_CONN, $urandom(), $urandom(), $urandom()));
                if ($urandom_range(0, 9) == 0)
                    req_queue.push_back(make_req($urandom(), $urandom(), $urandom(), $urandom()));
                if ($urandom_range(0, 14) == 0)
                    req_queue.push_back(make_req(REQ_CLEAR, $urandom(), $urandom(), $urandom()));
                queue_pattern($urandom_range(1, 6), $urandom_range(0, 2) != 0);
            end
            drain();
        end

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Guard against a hang
    initial
    begin
        #100ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
